>>> hdl/osi_pkg.sv
// ---------------------------------------------------------------------------
// osi_pkg: shared types and constants of the step integrator
// Word layouts, mode, method and register codes, and sequencer states.
// ---------------------------------------------------------------------------
package osi_pkg;

    localparam int FRAC_BITS_DEF = 32;
    localparam int DATA_W        = 64;
    localparam int STEP_W        = 63;
    localparam int CFG_IDX_W     = 2;

    localparam logic [1:0] MODE_LOAD_POS = 2'd0;
    localparam logic [1:0] MODE_LOAD_VEL = 2'd1;
    localparam logic [1:0] MODE_ACCEL    = 2'd2;

    localparam logic [1:0] METH_EULER    = 2'd0;
    localparam logic [1:0] METH_MIDPOINT = 2'd1;
    localparam logic [1:0] METH_RK4      = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_METHOD     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_TIME = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_END_TIME   = 2'd3;

    localparam logic [1:0] STAGE_LAST = 2'd3;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [63:0] value_x;
        logic signed [63:0] value_y;
        logic signed [63:0] value_z;
    } in_word_t;

    typedef struct packed {
        logic signed [63:0] pos_x;
        logic signed [63:0] pos_y;
        logic signed [63:0] pos_z;
        logic signed [63:0] vel_x;
        logic signed [63:0] vel_y;
        logic signed [63:0] vel_z;
        logic signed [63:0] sample_time;
        logic               step_done;
        logic               run_done;
    } out_word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_A,
        ST_MUL_B,
        ST_DIV_V,
        ST_DIV_P,
        ST_FINISH,
        ST_OUT
    } seq_state_t;

endpackage

>>> hdl/osi_mul.sv
// ---------------------------------------------------------------------------
// osi_mul: iterative fixed-point multiplier
// Signed value times unsigned step, four 32x32 partial products, floor scaled.
// ---------------------------------------------------------------------------
module osi_mul import osi_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [63:0] a,
    input  logic [STEP_W-1:0]  h,
    output logic               done,
    output logic signed [63:0] result
);

    logic [63:0]  mag_reg;
    logic [63:0]  h_reg;
    logic         neg_reg;
    logic [127:0] acc_reg;
    logic [63:0]  pp_reg;
    logic [1:0]   k_reg;
    logic [2:0]   cnt_reg;
    logic         busy_reg;
    logic         done_reg;
    logic [31:0]  op_a;
    logic [31:0]  op_b;
    logic [127:0] pp_shift;

    always_comb begin
        op_a = cnt_reg[1] ? mag_reg[63:32] : mag_reg[31:0];
        op_b = cnt_reg[0] ? h_reg[63:32] : h_reg[31:0];
        case (k_reg)
            2'd0:    pp_shift = {64'd0, pp_reg};
            2'd1:    pp_shift = {32'd0, pp_reg, 32'd0};
            default: pp_shift = {pp_reg, 64'd0};
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start && !busy_reg) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                neg_reg  <= a[63];
                mag_reg  <= a[63] ? 64'(-a) : 64'(a);
                h_reg    <= {1'b0, h};
                acc_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 3'd1;
                if (cnt_reg < 3'd4) begin
                    pp_reg <= op_a * op_b;
                    k_reg  <= {1'b0, cnt_reg[1]} + {1'b0, cnt_reg[0]};
                end
                if (cnt_reg >= 3'd1 && cnt_reg <= 3'd4) begin
                    acc_reg <= acc_reg + pp_shift;
                end
                if (cnt_reg == 3'd5) begin
                    if (neg_reg) begin
                        acc_reg <= -acc_reg;
                    end
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done   = done_reg;
    assign result = acc_reg[FRAC_BITS +: 64];

endmodule

>>> hdl/osi_div6.sv
// ---------------------------------------------------------------------------
// osi_div6: division by six by reciprocal multiplication
// Halves the magnitude, multiplies by a rounded-up reciprocal of three over
// four 32x32 partial products, and rounds the quotient toward zero.
// ---------------------------------------------------------------------------
module osi_div6 import osi_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [63:0] u,
    output logic               done,
    output logic signed [63:0] result
);

    // ceil(2^64 / 3): exact for every dividend below 2^63 after the top 64 bits.
    localparam logic [63:0] RECIP3 = 64'h5555_5555_5555_5556;

    logic [62:0]  num_reg;
    logic         neg_reg;
    logic [127:0] acc_reg;
    logic [63:0]  pp_reg;
    logic [1:0]   k_reg;
    logic [2:0]   cnt_reg;
    logic         busy_reg;
    logic         done_reg;
    logic [63:0]  quo_reg;
    logic [63:0]  mag;
    logic [31:0]  op_a;
    logic [31:0]  op_b;
    logic [127:0] pp_shift;

    always_comb begin
        mag  = u[63] ? 64'(-u) : 64'(u);
        op_a = cnt_reg[1] ? {1'b0, num_reg[62:32]} : num_reg[31:0];
        op_b = cnt_reg[0] ? RECIP3[63:32] : RECIP3[31:0];
        case (k_reg)
            2'd0:    pp_shift = {64'd0, pp_reg};
            2'd1:    pp_shift = {32'd0, pp_reg, 32'd0};
            default: pp_shift = {pp_reg, 64'd0};
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start && !busy_reg) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                neg_reg  <= u[63];
                num_reg  <= mag[63:1];
                acc_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 3'd1;
                if (cnt_reg < 3'd4) begin
                    pp_reg <= op_a * op_b;
                    k_reg  <= {1'b0, cnt_reg[1]} + {1'b0, cnt_reg[0]};
                end
                if (cnt_reg >= 3'd1 && cnt_reg <= 3'd4) begin
                    acc_reg <= acc_reg + pp_shift;
                end
                if (cnt_reg == 3'd5) begin
                    quo_reg  <= neg_reg ? -acc_reg[127:64] : acc_reg[127:64];
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done   = done_reg;
    assign result = quo_reg;

endmodule

>>> hdl/ode_step_integrator.sv
// ---------------------------------------------------------------------------
// ode_step_integrator: fixed-point 3-D step integrator
// Semi-implicit Euler, midpoint or RK4 stages driven by acceleration samples.
// ---------------------------------------------------------------------------
// Each input word returns one result word. A load, an unused mode or a sample
// after the run has ended offers its result word the cycle after it is
// accepted. An acceleration sample is processed one axis after another on one
// shared multiplier, two products per axis, before the result word is put out.
// The last RK4 stage adds two divisions by six per axis, each a reciprocal
// multiplication. The block is not ready while a sample is in work or a
// result waits to be taken.
module ode_step_integrator import osi_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_word_t             s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_word_t            m_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data
);

    logic [1:0]         method_reg;
    logic [STEP_W-1:0]  step_reg;
    logic signed [63:0] start_time_reg;
    logic signed [63:0] end_time_reg;

    logic signed [63:0] bp_reg [3];
    logic signed [63:0] bv_reg [3];
    logic signed [63:0] pp_reg [3];
    logic signed [63:0] pv_reg [3];
    logic signed [63:0] sp_reg [3];
    logic signed [63:0] sv_reg [3];
    logic signed [63:0] acc_in_reg [3];
    logic signed [63:0] kv_reg;
    logic [1:0]         stage_reg;
    logic signed [63:0] time_reg;
    logic               finished_reg;
    logic signed [63:0] stime_reg;
    logic               done_flag_reg;
    logic [1:0]         ax_reg;
    logic [1:0]         meth_reg;
    logic               issued_reg;

    seq_state_t state_reg, state_next;

    logic               mul_start, mul_done, div_start, div_done;
    logic signed [63:0] mul_a, mul_res, div_u, div_res;
    logic               accept;
    logic signed [63:0] r, kv2, kx2, time_sum, time_new;
    logic [1:0]         stage_new;
    logic               step_end;

    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);

    osi_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .aclk(aclk), .aresetn(aresetn), .start(mul_start), .a(mul_a),
        .h(step_reg), .done(mul_done), .result(mul_res)
    );

    osi_div6 u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .u(div_u),
        .done(div_done), .result(div_res)
    );

    always_comb begin
        mul_a = (state_reg == ST_MUL_A) ? acc_in_reg[ax_reg] : pv_reg[ax_reg];
        div_u = (state_reg == ST_DIV_V) ? sv_reg[ax_reg] : sp_reg[ax_reg];
        mul_start = ((state_reg == ST_MUL_A) || (state_reg == ST_MUL_B)) && !issued_reg;
        div_start = ((state_reg == ST_DIV_V) || (state_reg == ST_DIV_P)) && !issued_reg;
        r   = (state_reg == ST_MUL_A || state_reg == ST_MUL_B) ? mul_res : div_res;
        kv2 = {kv_reg[62:0], 1'b0};
        kx2 = {mul_res[62:0], 1'b0};
        time_sum = time_reg + $signed({1'b0, step_reg});
        time_new = (!time_reg[63] && time_sum[63]) ? {1'b0, {63{1'b1}}} : time_sum;
        step_end = 1'b0;
        stage_new = 2'd0;
        unique case (meth_reg)
            METH_EULER:    step_end = 1'b1;
            METH_MIDPOINT: begin
                step_end  = (stage_reg != 2'd0);
                stage_new = step_end ? 2'd0 : 2'd1;
            end
            default: begin
                step_end  = (stage_reg == STAGE_LAST);
                stage_new = step_end ? 2'd0 : 2'(stage_reg + 2'd1);
            end
        endcase
    end

    // Sequencer: one axis at a time through the shared units.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_data.mode == MODE_ACCEL && !finished_reg
                        && !(time_reg > end_time_reg)) begin
                        state_next = ST_MUL_A;
                    end else begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_MUL_A: if (mul_done) state_next = ST_MUL_B;
            ST_MUL_B: begin
                if (mul_done) begin
                    if (meth_reg == METH_RK4 && stage_reg == STAGE_LAST) begin
                        state_next = ST_DIV_V;
                    end else if (ax_reg == 2'd2) begin
                        state_next = ST_FINISH;
                    end else begin
                        state_next = ST_MUL_A;
                    end
                end
            end
            ST_DIV_V: if (div_done) state_next = ST_DIV_P;
            ST_DIV_P: begin
                if (div_done) state_next = (ax_reg == 2'd2) ? ST_FINISH : ST_MUL_A;
            end
            ST_FINISH: state_next = ST_OUT;
            ST_OUT:    if (m_ready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            method_reg     <= METH_RK4;
            step_reg       <= STEP_W'(64'd1 << FRAC_BITS);
            start_time_reg <= '0;
            end_time_reg   <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_METHOD:     method_reg     <= cfg_data[1:0];
                REG_STEP:       step_reg       <= cfg_data[STEP_W-1:0];
                REG_START_TIME: start_time_reg <= cfg_data;
                REG_END_TIME:   end_time_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                bp_reg[i] <= '0;
                bv_reg[i] <= '0;
                pp_reg[i] <= '0;
                pv_reg[i] <= '0;
                sp_reg[i] <= '0;
                sv_reg[i] <= '0;
            end
            stage_reg     <= '0;
            time_reg      <= '0;
            finished_reg  <= 1'b0;
            issued_reg    <= 1'b0;
            ax_reg        <= '0;
            meth_reg      <= METH_RK4;
            done_flag_reg <= 1'b0;
            stime_reg     <= '0;
        end else begin
            if (mul_start || div_start) issued_reg <= 1'b1;
            if (mul_done || div_done)   issued_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        done_flag_reg <= 1'b0;
                        stime_reg     <= '0;
                        ax_reg        <= '0;
                        meth_reg      <= (method_reg == METH_EULER ||
                                          method_reg == METH_MIDPOINT) ? method_reg
                                                                       : METH_RK4;
                        acc_in_reg[0] <= s_data.value_x;
                        acc_in_reg[1] <= s_data.value_y;
                        acc_in_reg[2] <= s_data.value_z;
                        if (s_data.mode == MODE_LOAD_POS || s_data.mode == MODE_LOAD_VEL) begin
                            for (int i = 0; i < 3; i++) begin
                                sp_reg[i] <= '0;
                                sv_reg[i] <= '0;
                            end
                            if (s_data.mode == MODE_LOAD_POS) begin
                                bp_reg[0] <= s_data.value_x;
                                bp_reg[1] <= s_data.value_y;
                                bp_reg[2] <= s_data.value_z;
                                pp_reg[0] <= s_data.value_x;
                                pp_reg[1] <= s_data.value_y;
                                pp_reg[2] <= s_data.value_z;
                                for (int i = 0; i < 3; i++) begin
                                    pv_reg[i] <= bv_reg[i];
                                end
                            end else begin
                                bv_reg[0] <= s_data.value_x;
                                bv_reg[1] <= s_data.value_y;
                                bv_reg[2] <= s_data.value_z;
                                pv_reg[0] <= s_data.value_x;
                                pv_reg[1] <= s_data.value_y;
                                pv_reg[2] <= s_data.value_z;
                                for (int i = 0; i < 3; i++) begin
                                    pp_reg[i] <= bp_reg[i];
                                end
                            end
                            stage_reg    <= '0;
                            time_reg     <= start_time_reg;
                            finished_reg <= (start_time_reg > end_time_reg);
                        end else if (s_data.mode == MODE_ACCEL) begin
                            if (finished_reg || (time_reg > end_time_reg)) begin
                                finished_reg <= 1'b1;
                            end
                        end
                    end
                end
                ST_MUL_A: begin
                    if (mul_done) begin
                        kv_reg <= r;
                        unique case (meth_reg)
                            METH_EULER: begin
                                bv_reg[ax_reg] <= bv_reg[ax_reg] + r;
                                pv_reg[ax_reg] <= bv_reg[ax_reg] + r;
                            end
                            METH_MIDPOINT: begin
                                if (stage_reg == 2'd0) begin
                                    pv_reg[ax_reg] <= bv_reg[ax_reg] + (r >>> 1);
                                end else begin
                                    pv_reg[ax_reg] <= pv_reg[ax_reg] + (r >>> 1);
                                    bv_reg[ax_reg] <= pv_reg[ax_reg] + (r >>> 1);
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_MUL_B: begin
                    if (mul_done) begin
                        if (!(meth_reg == METH_RK4 && stage_reg == STAGE_LAST)) begin
                            ax_reg <= 2'(ax_reg + 2'd1);
                        end
                        unique case (meth_reg)
                            METH_EULER: begin
                                bp_reg[ax_reg] <= bp_reg[ax_reg] + r;
                                pp_reg[ax_reg] <= bp_reg[ax_reg] + r;
                            end
                            METH_MIDPOINT: begin
                                if (stage_reg == 2'd0) begin
                                    pp_reg[ax_reg] <= bp_reg[ax_reg] + (r >>> 1);
                                end else begin
                                    pp_reg[ax_reg] <= pp_reg[ax_reg] + (r >>> 1);
                                    bp_reg[ax_reg] <= pp_reg[ax_reg] + (r >>> 1);
                                end
                            end
                            default: begin
                                unique case (stage_reg)
                                    2'd0: begin
                                        sv_reg[ax_reg] <= kv_reg;
                                        sp_reg[ax_reg] <= r;
                                        pv_reg[ax_reg] <= bv_reg[ax_reg] + (kv_reg >>> 1);
                                        pp_reg[ax_reg] <= bp_reg[ax_reg] + (r >>> 1);
                                    end
                                    2'd1: begin
                                        sv_reg[ax_reg] <= sv_reg[ax_reg] + kv2;
                                        sp_reg[ax_reg] <= sp_reg[ax_reg] + kx2;
                                        pv_reg[ax_reg] <= bv_reg[ax_reg] + (kv_reg >>> 1);
                                        pp_reg[ax_reg] <= bp_reg[ax_reg] + (r >>> 1);
                                    end
                                    2'd2: begin
                                        sv_reg[ax_reg] <= sv_reg[ax_reg] + kv2;
                                        sp_reg[ax_reg] <= sp_reg[ax_reg] + kx2;
                                        pv_reg[ax_reg] <= bv_reg[ax_reg] + kv_reg;
                                        pp_reg[ax_reg] <= bp_reg[ax_reg] + r;
                                    end
                                    default: begin
                                        sv_reg[ax_reg] <= sv_reg[ax_reg] + kv_reg;
                                        sp_reg[ax_reg] <= sp_reg[ax_reg] + r;
                                    end
                                endcase
                            end
                        endcase
                    end
                end
                ST_DIV_V: begin
                    if (div_done) begin
                        bv_reg[ax_reg] <= bv_reg[ax_reg] + r;
                        pv_reg[ax_reg] <= bv_reg[ax_reg] + r;
                    end
                end
                ST_DIV_P: begin
                    if (div_done) begin
                        bp_reg[ax_reg] <= bp_reg[ax_reg] + r;
                        pp_reg[ax_reg] <= bp_reg[ax_reg] + r;
                        ax_reg <= 2'(ax_reg + 2'd1);
                    end
                end
                ST_FINISH: begin
                    stage_reg     <= stage_new;
                    done_flag_reg <= step_end;
                    if (step_end) begin
                        stime_reg    <= time_reg;
                        time_reg     <= time_new;
                        finished_reg <= (time_new > end_time_reg);
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        m_data.pos_x       = pp_reg[0];
        m_data.pos_y       = pp_reg[1];
        m_data.pos_z       = pp_reg[2];
        m_data.vel_x       = pv_reg[0];
        m_data.vel_y       = pv_reg[1];
        m_data.vel_z       = pv_reg[2];
        m_data.sample_time = stime_reg;
        m_data.step_done   = done_flag_reg;
        m_data.run_done    = finished_reg;
    end

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input taken while a result is pending");

    a_stime_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.step_done) |-> (m_data.sample_time == 64'sd0))
        else $error("sample time set without a finished step");

    a_load_fast: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_data.mode != MODE_ACCEL) |=> (m_valid && !m_data.step_done))
        else $error("load did not return its word at once");

endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench: self-checking bench for the fixed-point step integrator
// Loads bodies, feeds acceleration samples under random idling on both
// channels, walks the four registers through several settings including
// their extremes, and checks every result word against an in-bench predictor.
// ---------------------------------------------------------------------------
module testbench;
    import osi_pkg::*;

    localparam longint LIMIT_CYCLES = 64'd4000000;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    in_word_t             s_data;
    logic                 m_valid;
    logic                 m_ready;
    out_word_t            m_data;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DATA_W-1:0]    cfg_data;

    longint cycle_count = 0;
    int     words_sent = 0;
    int     steps_seen = 0;
    int     runs_ended = 0;

    ode_step_integrator i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predictor of the integrator plus the queue of result words it expects.
    class integrator_scoreboard;
        logic [1:0]  method_q;
        logic [62:0] step_q;
        logic [63:0] t_start;
        logic [63:0] t_end;
        logic [63:0] base_p[3], base_v[3], probe_p[3], probe_v[3];
        logic [63:0] acc_p[3], acc_v[3];
        logic [1:0]  stage;
        logic [63:0] now;
        logic        finished;
        out_word_t   pending[$];
        int          errors;

        function new();
            errors = 0;
            clear();
        endfunction

        function void clear();
            method_q = METH_RK4;
            step_q = 63'h1 << FRAC_BITS_DEF;
            t_start = '0;
            t_end = '0;
            for (int i = 0; i < 3; i++) begin
                base_p[i] = '0; base_v[i] = '0; probe_p[i] = '0;
                probe_v[i] = '0; acc_p[i] = '0; acc_v[i] = '0;
            end
            stage = '0;
            now = '0;
            finished = 1'b0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
            case (idx)
                REG_METHOD:     method_q = val[1:0];
                REG_STEP:       step_q = val[62:0];
                REG_START_TIME: t_start = val;
                default:        t_end = val;
            endcase
        endfunction

        function logic [63:0] scaled(logic [63:0] a, logic [62:0] h);
            logic signed [127:0] p;
            p = $signed(a) * $signed({65'd0, h});
            return p[FRAC_BITS_DEF +: 64];
        endfunction

        function logic [63:0] halved(logic [63:0] u);
            return {u[63], u[63:1]};
        endfunction

        function logic [63:0] sixth(logic [63:0] u);
            return $signed(u) / 64'sd6;
        endfunction

        function void note_input(in_word_t w);
            out_word_t   r;
            logic [1:0]  meth;
            logic [1:0]  st;
            logic [63:0] av, kx, v, x, tsum;
            logic        done;
            meth = (method_q == 2'd3) ? METH_RK4 : method_q;
            done = 1'b0;
            r = '0;
            if (w.mode == MODE_LOAD_POS || w.mode == MODE_LOAD_VEL) begin
                for (int i = 0; i < 3; i++) begin
                    v = (i == 0) ? w.value_x : (i == 1) ? w.value_y : w.value_z;
                    if (w.mode == MODE_LOAD_POS) base_p[i] = v;
                    else base_v[i] = v;
                    probe_p[i] = base_p[i];
                    probe_v[i] = base_v[i];
                    acc_p[i] = '0;
                    acc_v[i] = '0;
                end
                stage = '0;
                now = t_start;
                finished = $signed(now) > $signed(t_end);
            end else if (w.mode == MODE_ACCEL) begin
                if (finished || $signed(now) > $signed(t_end)) begin
                    finished = 1'b1;
                end else begin
                    st = stage;
                    for (int i = 0; i < 3; i++) begin
                        v = (i == 0) ? w.value_x : (i == 1) ? w.value_y : w.value_z;
                        av = scaled(v, step_q);
                        if (meth == METH_EULER) begin
                            base_v[i] += av;
                            base_p[i] += scaled(base_v[i], step_q);
                            probe_v[i] = base_v[i];
                            probe_p[i] = base_p[i];
                        end else if (meth == METH_MIDPOINT) begin
                            if (st == 2'd0) begin
                                probe_v[i] = base_v[i] + halved(av);
                                probe_p[i] = base_p[i] + halved(scaled(probe_v[i], step_q));
                            end else begin
                                v = probe_v[i] + halved(av);
                                x = probe_p[i] + halved(scaled(v, step_q));
                                base_v[i] = v; probe_v[i] = v;
                                base_p[i] = x; probe_p[i] = x;
                            end
                        end else begin
                            kx = scaled(probe_v[i], step_q);
                            if (st == 2'd0) begin
                                acc_v[i] = av;
                                acc_p[i] = kx;
                            end else if (st == STAGE_LAST) begin
                                acc_v[i] += av;
                                acc_p[i] += kx;
                            end else begin
                                acc_v[i] += av << 1;
                                acc_p[i] += kx << 1;
                            end
                            if (st == STAGE_LAST) begin
                                base_v[i] += sixth(acc_v[i]);
                                base_p[i] += sixth(acc_p[i]);
                                probe_v[i] = base_v[i];
                                probe_p[i] = base_p[i];
                            end else if (st == 2'd2) begin
                                probe_v[i] = base_v[i] + av;
                                probe_p[i] = base_p[i] + kx;
                            end else begin
                                probe_v[i] = base_v[i] + halved(av);
                                probe_p[i] = base_p[i] + halved(kx);
                            end
                        end
                    end
                    if (meth == METH_EULER) begin
                        stage = '0; done = 1'b1;
                    end else if (meth == METH_MIDPOINT) begin
                        done = (st != 2'd0);
                        stage = done ? 2'd0 : 2'd1;
                    end else begin
                        done = (st == STAGE_LAST);
                        stage = st + 2'd1;
                    end
                    if (done) begin
                        r.sample_time = now;
                        tsum = now + {1'b0, step_q};
                        now = (!now[63] && tsum[63]) ? 64'h7fff_ffff_ffff_ffff : tsum;
                        finished = $signed(now) > $signed(t_end);
                    end
                end
            end
            r.pos_x = probe_p[0]; r.pos_y = probe_p[1]; r.pos_z = probe_p[2];
            r.vel_x = probe_v[0]; r.vel_y = probe_v[1]; r.vel_z = probe_v[2];
            r.step_done = done;
            r.run_done = finished;
            pending.push_back(r);
        endfunction

        function void fail(string field, logic [63:0] e, logic [63:0] a);
            $error("%s mismatch: expected %h, got %h", field, e, a);
            errors++;
        endfunction

        function void check_result(out_word_t got);
            out_word_t e;
            if (pending.size() == 0) begin
                $error("result word arrived with nothing expected");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.pos_x !== e.pos_x) fail("pos_x", e.pos_x, got.pos_x);
            if (got.pos_y !== e.pos_y) fail("pos_y", e.pos_y, got.pos_y);
            if (got.pos_z !== e.pos_z) fail("pos_z", e.pos_z, got.pos_z);
            if (got.vel_x !== e.vel_x) fail("vel_x", e.vel_x, got.vel_x);
            if (got.vel_y !== e.vel_y) fail("vel_y", e.vel_y, got.vel_y);
            if (got.vel_z !== e.vel_z) fail("vel_z", e.vel_z, got.vel_z);
            if (got.sample_time !== e.sample_time)
                fail("sample_time", e.sample_time, got.sample_time);
            if (got.step_done !== e.step_done)
                fail("step_done", e.step_done, got.step_done);
            if (got.run_done !== e.run_done)
                fail("run_done", e.run_done, got.run_done);
        endfunction
    endclass

    integrator_scoreboard board = new();

    always begin
        aclk = 1'b1; #5;
        aclk = 1'b0; #5;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Both handshakes are observed at the rising edge.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            board.note_input(s_data);
            words_sent++;
        end
        if (aresetn && m_valid && m_ready) begin
            if (m_data.step_done) steps_seen++;
            if (m_data.run_done) runs_ended++;
            board.check_result(m_data);
        end
    end

    // Result side: random stalls, often none at all.
    initial begin
        int stall;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
            m_ready = 1'b0;
            repeat (stall) @(negedge aclk);
            m_ready = 1'b1;
            @(posedge aclk);
            while (!(m_valid && m_ready)) @(posedge aclk);
        end
    end

    bit calm;

    task automatic send_word(logic [1:0] mode, logic [63:0] x, logic [63:0] y,
                             logic [63:0] z);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 13);
        repeat (gap) @(negedge aclk);
        s_data = {mode, x, y, z};
        s_valid = 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    // Waits until every expected result is back, then lets the block settle.
    task automatic drain();
        while (board.pending.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
        @(negedge aclk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        board.write_reg(idx, val);
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Values of modest size keep trajectories meaningful; some are full range.
    function automatic logic [63:0] rand_value();
        case ($urandom_range(0, 5))
            0:       return rand64();
            1:       return {{8{1'b0}}, 56'($urandom()) };
            default: return 64'($signed({$urandom_range(0, 255), 32'($urandom())}) -
                                64'sd549755813888);
        endcase
    endfunction

    task automatic rand_config(int phase);
        logic [63:0] h;
        case ($urandom_range(0, 4))
            0:       h = 64'h7fff_ffff_ffff_ffff;
            1:       h = 64'd1;
            2:       h = 64'd0;
            default: h = {42'd0, 22'($urandom())} << 12;
        endcase
        write_reg(REG_METHOD, 64'($urandom_range(0, 3)));
        write_reg(REG_STEP, h);
        write_reg(REG_START_TIME, (phase % 7 == 3) ? 64'h8000_0000_0000_0000 :
                                  64'($signed($urandom_range(0, 63) - 8)) << 32);
        write_reg(REG_END_TIME, (phase % 5 == 2) ? 64'h7fff_ffff_ffff_ffff :
                                64'($urandom_range(0, 200)) << 32);
    endtask

    initial begin
        logic [63:0] big, neg;
        int n, samples;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_we = 1'b0;
        cfg_index = REG_METHOD;
        cfg_data = '0;
        calm = 1'b0;
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;

        // Directed part: extreme loads, each method, unused mode and method,
        // samples after the run ended, saturating time and a zero step.
        big = 64'h7fff_ffff_ffff_ffff;
        neg = 64'h8000_0000_0000_0000;
        write_reg(REG_END_TIME, 64'd3 << 32);
        send_word(MODE_LOAD_POS, big, neg, 64'hffff_ffff_ffff_ffff);
        send_word(MODE_LOAD_VEL, neg, big, 64'd1);
        repeat (4) send_word(MODE_ACCEL, big, neg, 64'd0);
        send_word(2'd3, neg, neg, neg);
        drain();
        write_reg(REG_METHOD, {62'd0, METH_EULER});
        write_reg(REG_STEP, big);
        send_word(MODE_ACCEL, neg, big, -64'sd5);
        send_word(MODE_ACCEL, 64'd7, 64'd7, 64'd7);
        drain();
        write_reg(REG_METHOD, {62'd0, METH_MIDPOINT});
        write_reg(REG_STEP, 64'd1 << 31);
        write_reg(REG_START_TIME, neg);
        write_reg(REG_END_TIME, big);
        send_word(MODE_LOAD_POS, 64'd0, 64'd0, 64'd0);
        repeat (3) send_word(MODE_ACCEL, -64'sd100 << 32, 64'd3 << 32, big);
        drain();
        write_reg(REG_METHOD, 64'd3);
        write_reg(REG_STEP, 64'd0);
        repeat (5) send_word(MODE_ACCEL, 64'd1 << 32, neg, big);
        drain();
        write_reg(REG_START_TIME, big);
        write_reg(REG_END_TIME, neg);
        send_word(MODE_LOAD_VEL, 64'd2, 64'd2, 64'd2);
        send_word(MODE_ACCEL, 64'd2, 64'd2, 64'd2);
        drain();

        // Random part: loads followed by runs of samples, plus noise words.
        n = 0;
        for (int phase = 0; n < 1630; phase++) begin
            rand_config(phase);
            calm = (phase % 4 == 1);
            send_word(MODE_LOAD_POS, rand_value(), rand_value(), rand_value());
            send_word(MODE_LOAD_VEL, rand_value(), rand_value(), rand_value());
            n += 2;
            samples = $urandom_range(4, 24);
            for (int k = 0; k < samples; k++) begin
                case ($urandom_range(0, 19))
                    0:       send_word(2'd3, rand64(), rand64(), rand64());
                    1:       send_word(MODE_ACCEL, rand64(), rand64(), rand64());
                    2:       send_word(2'($urandom_range(0, 1)), rand_value(),
                                       rand_value(), rand_value());
                    default: send_word(MODE_ACCEL, rand_value(), rand_value(),
                                       rand_value());
                endcase
                n++;
            end
            // Hold the sender until every result of this phase is back.
            drain();
        end
        calm = 1'b0;
        drain();

        $display("Sent %0d input words; %0d results finished a step, %0d flagged run end.",
                 words_sent, steps_seen, runs_ended);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
